FILE: rtl/core/nmnd_pkg.sv
// ----------------------------------------------------------------------------
// Nearest marked node distance: shared package
// Sizes, command codes, word types and sequencer states.
// ----------------------------------------------------------------------------
package nmnd_pkg;

    localparam int MAX_NODES      = 64;
    localparam int NODE_BITS      = $clog2(MAX_NODES);
    localparam int CFG_BITS       = 7;
    localparam int WEIGHT_BITS    = 16;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int DIST_BITS      = 32;
    localparam int OUT_DIST_BITS  = 31;
    localparam int EDGE_ADDR_BITS = 2 * NODE_BITS;
    localparam int EDGE_DEPTH     = MAX_NODES * MAX_NODES;
    localparam int EDGE_BITS      = WEIGHT_BITS + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_BITS-1:0]      NODE_COUNT_RESET = CFG_BITS'(64);
    localparam logic [CFG_BITS-1:0]      NODE_LIMIT       = CFG_BITS'(MAX_NODES);
    localparam logic [OUT_DIST_BITS-1:0] DIST_NONE        = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_MARK     = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]                command;
        logic [5:0]                node_a;
        logic [5:0]                node_b;
        logic [IN_WEIGHT_BITS-1:0] weight;
    } t_in_word;

    typedef struct packed {
        logic [OUT_DIST_BITS-1:0] distance;
        logic                     reachable;
    } t_out_word;

    typedef struct packed {
        t_cmd                   op;
        logic                   in_range;
        logic [NODE_BITS-1:0]   node_a;
        logic [NODE_BITS-1:0]   node_b;
        logic [WEIGHT_BITS-1:0] weight;
    } t_job;

    typedef struct packed {
        logic                clearing;
        logic [CFG_BITS-1:0] node_limit;
    } t_back_status;

    typedef enum logic [3:0] {
        BK_INIT,
        BK_IDLE,
        BK_EDGE_RD,
        BK_EDGE_WAIT,
        BK_EDGE_WR2,
        BK_CLEAR,
        BK_SCAN,
        BK_RELAX,
        BK_RESULT
    } t_back_state;

endpackage

FILE: rtl/core/nmnd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nmnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/nmnd_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accept input words, decode and range-check them, queue them for the back end.
// ----------------------------------------------------------------------------
module nmnd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  nmnd_pkg::t_in_word    i_in_word,
    input  nmnd_pkg::t_back_status i_status,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output nmnd_pkg::t_job        o_job
);
    import nmnd_pkg::*;

    t_job                    r_queue [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS:0] r_rd_ptr, n_rd_ptr;
    logic                    full, empty, push, pop;
    t_job                    job_in;
    logic                    a_ok, b_ok;

    assign full  = (r_wr_ptr[QUEUE_PTR_BITS] != r_rd_ptr[QUEUE_PTR_BITS]) &&
                   (r_wr_ptr[QUEUE_PTR_BITS-1:0] == r_rd_ptr[QUEUE_PTR_BITS-1:0]);
    assign empty = (r_wr_ptr == r_rd_ptr);

    assign o_in_ready  = !full && !i_status.clearing;
    assign push        = i_in_valid && o_in_ready;
    assign o_job_valid = !empty;
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_queue[r_rd_ptr[QUEUE_PTR_BITS-1:0]];

    always_comb begin
        a_ok            = {1'b0, i_in_word.node_a} < i_status.node_limit;
        b_ok            = {1'b0, i_in_word.node_b} < i_status.node_limit;
        job_in.op       = t_cmd'(i_in_word.command);
        job_in.node_a   = i_in_word.node_a;
        job_in.node_b   = i_in_word.node_b;
        job_in.weight   = i_in_word.weight[WEIGHT_BITS-1:0];
        job_in.in_range = a_ok && (b_ok || (job_in.op != CMD_ADD_EDGE));
        n_wr_ptr        = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr        = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr[QUEUE_PTR_BITS-1:0]] <= job_in;
        end
    end

endmodule

FILE: rtl/core/nmnd_back.sv
// ----------------------------------------------------------------------------
// Back end
// Sequence graph updates, clearing sweeps and shortest-path queries.
// ----------------------------------------------------------------------------
module nmnd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [6:0]             i_cfg_data,
    input  logic                   i_job_valid,
    output logic                   o_job_ready,
    input  nmnd_pkg::t_job         i_job,
    output nmnd_pkg::t_back_status o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output nmnd_pkg::t_out_word    o_out_word
);
    import nmnd_pkg::*;

    t_back_state r_state, n_state;

    logic [CFG_BITS-1:0]       r_node_count;
    logic [CFG_BITS-1:0]       node_lim;
    logic [MAX_NODES-1:0]      r_marked, n_marked;
    logic [MAX_NODES-1:0]      r_reached, n_reached;
    logic [MAX_NODES-1:0]      r_settled, n_settled;
    logic [EDGE_ADDR_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [CFG_BITS-1:0]       r_idx, n_idx;
    logic                      r_pend, n_pend;
    logic [NODE_BITS-1:0]      r_pidx, n_pidx;
    logic                      r_found, n_found;
    logic [NODE_BITS-1:0]      r_best, n_best;
    logic [DIST_BITS-1:0]      r_bestd, n_bestd;
    logic [NODE_BITS-1:0]      r_node_a, n_node_a;
    logic [NODE_BITS-1:0]      r_node_b, n_node_b;
    logic [WEIGHT_BITS-1:0]    r_weight, n_weight;
    logic                      r_res_reach, n_res_reach;
    logic [DIST_BITS-1:0]      r_res_dist, n_res_dist;
    logic                      r_out_valid, n_out_valid;
    t_out_word                 r_out_word, n_out_word;

    logic                      edge_we;
    logic [EDGE_ADDR_BITS-1:0] edge_waddr, edge_raddr;
    logic [EDGE_BITS-1:0]      edge_wdata, edge_rdata;
    logic                      dist_we;
    logic [NODE_BITS-1:0]      dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0]      dist_wdata, dist_rdata;
    logic [DIST_BITS-1:0]      relax_d;
    logic [WEIGHT_BITS-1:0]    new_w;
    logic                      issue;

    nmnd_ram #(.WIDTH(EDGE_BITS), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_waddr(edge_waddr),
        .i_wdata(edge_wdata),
        .i_raddr(edge_raddr),
        .o_rdata(edge_rdata)
    );

    nmnd_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES)) u_dist_ram (
        .i_clk  (i_clk),
        .i_we   (dist_we),
        .i_waddr(dist_waddr),
        .i_wdata(dist_wdata),
        .i_raddr(dist_raddr),
        .o_rdata(dist_rdata)
    );

    assign node_lim            = (r_node_count > NODE_LIMIT) ? NODE_LIMIT : r_node_count;
    assign o_status.clearing   = (r_state == BK_INIT);
    assign o_status.node_limit = node_lim;
    assign o_out_valid         = r_out_valid;
    assign o_out_word          = r_out_word;
    assign relax_d             = r_bestd + DIST_BITS'(edge_rdata[WEIGHT_BITS-1:0]);
    assign issue               = (r_idx < node_lim);
    assign new_w               = (!edge_rdata[WEIGHT_BITS] ||
                                  (r_weight < edge_rdata[WEIGHT_BITS-1:0])) ?
                                 r_weight : edge_rdata[WEIGHT_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_marked    = r_marked;
        n_reached   = r_reached;
        n_settled   = r_settled;
        n_clr_addr  = r_clr_addr;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_idx[NODE_BITS-1:0];
        n_found     = r_found;
        n_best      = r_best;
        n_bestd     = r_bestd;
        n_node_a    = r_node_a;
        n_node_b    = r_node_b;
        n_weight    = r_weight;
        n_res_reach = r_res_reach;
        n_res_dist  = r_res_dist;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        o_job_ready = 1'b0;
        edge_we     = 1'b0;
        edge_waddr  = {r_node_a, r_node_b};
        edge_wdata  = {1'b1, r_weight};
        edge_raddr  = {r_node_a, r_node_b};
        dist_we     = 1'b0;
        dist_waddr  = r_pidx;
        dist_wdata  = relax_d;
        dist_raddr  = r_idx[NODE_BITS-1:0];

        case (r_state)
            BK_INIT, BK_CLEAR: begin
                edge_we    = 1'b1;
                edge_waddr = r_clr_addr;
                edge_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_marked = '0;
                    n_state  = BK_IDLE;
                end
            end
            BK_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_node_a = i_job.node_a;
                    n_node_b = i_job.node_b;
                    n_weight = i_job.weight;
                    case (i_job.op)
                        CMD_ADD_EDGE: begin
                            if (i_job.in_range) begin
                                n_state = BK_EDGE_RD;
                            end
                        end
                        CMD_MARK: begin
                            if (i_job.in_range) begin
                                n_marked[i_job.node_a] = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = BK_CLEAR;
                        end
                        CMD_QUERY: begin
                            if (i_job.in_range) begin
                                dist_we                 = 1'b1;
                                dist_waddr              = i_job.node_a;
                                dist_wdata              = '0;
                                n_reached               = '0;
                                n_reached[i_job.node_a] = 1'b1;
                                n_settled               = '0;
                                n_idx                   = '0;
                                n_found                 = 1'b0;
                                n_state                 = BK_SCAN;
                            end else begin
                                n_res_reach = 1'b0;
                                n_res_dist  = DIST_BITS'(DIST_NONE);
                                n_state     = BK_RESULT;
                            end
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_EDGE_RD: begin
                n_state = BK_EDGE_WAIT;
            end
            BK_EDGE_WAIT: begin
                edge_we    = 1'b1;
                edge_wdata = {1'b1, new_w};
                n_weight   = new_w;
                n_state    = BK_EDGE_WR2;
            end
            BK_EDGE_WR2: begin
                edge_we    = 1'b1;
                edge_waddr = {r_node_b, r_node_a};
                n_state    = BK_IDLE;
            end
            BK_SCAN: begin
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (r_reached[r_pidx] && !r_settled[r_pidx] &&
                        (!r_found || (dist_rdata < r_bestd))) begin
                        n_found = 1'b1;
                        n_best  = r_pidx;
                        n_bestd = dist_rdata;
                    end
                end else if (!issue) begin
                    if (!r_found) begin
                        n_res_reach = 1'b0;
                        n_res_dist  = DIST_BITS'(DIST_NONE);
                        n_state     = BK_RESULT;
                    end else if (r_marked[r_best]) begin
                        n_res_reach = 1'b1;
                        n_res_dist  = r_bestd;
                        n_state     = BK_RESULT;
                    end else begin
                        n_settled[r_best] = 1'b1;
                        n_idx             = '0;
                        n_state           = BK_RELAX;
                    end
                end
            end
            BK_RELAX: begin
                edge_raddr = {r_best, r_idx[NODE_BITS-1:0]};
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (edge_rdata[WEIGHT_BITS] && !r_settled[r_pidx] &&
                        (!r_reached[r_pidx] || (relax_d < dist_rdata))) begin
                        dist_we           = 1'b1;
                        n_reached[r_pidx] = 1'b1;
                    end
                end else if (!issue) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = BK_SCAN;
                end
            end
            BK_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_word.reachable = r_res_reach;
                    n_out_word.distance  = (r_res_dist > DIST_BITS'(DIST_NONE)) ?
                                           DIST_NONE : r_res_dist[OUT_DIST_BITS-1:0];
                    n_state              = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_INIT;
            r_clr_addr   <= '0;
            r_node_count <= NODE_COUNT_RESET;
            r_marked     <= '0;
            r_reached    <= '0;
            r_settled    <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_node_count <= i_cfg_we ? i_cfg_data : r_node_count;
            r_marked     <= n_marked;
            r_reached    <= n_reached;
            r_settled    <= n_settled;
            r_pend       <= n_pend;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_best      <= n_best;
        r_bestd     <= n_bestd;
        r_node_a    <= n_node_a;
        r_node_b    <= n_node_b;
        r_weight    <= n_weight;
        r_res_reach <= n_res_reach;
        r_res_dist  <= n_res_dist;
        r_out_word  <= n_out_word;
    end

endmodule

FILE: rtl/core/nearest_marked_node_distance.sv
// ----------------------------------------------------------------------------
// Nearest marked node distance
// Weighted undirected graph store with a shortest-path search to the nearest
// marked node.
//
//   channel   direction  handshake            word
//   in        input      i_in_valid/o_in_ready  t_in_word
//   out       output     o_out_valid/i_out_ready t_out_word
//   cfg       input      i_cfg_we             i_cfg_data (node count)
//
// Add edge stores the smaller weight both ways; clear sweeps the edge RAM.
// A query repeats a scan pass for the nearest unsettled reached node and a
// relax pass over its edges, both over the first n nodes, n the node count.
// After reset a sweep clears the edge RAM; o_in_ready stays low during it.
// A four-word queue holds input words while the back end is busy or stalled.
// ----------------------------------------------------------------------------
module nearest_marked_node_distance (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nmnd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nmnd_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data
);
    import nmnd_pkg::*;

    logic         job_valid, job_ready;
    t_job         job;
    t_back_status status;

    nmnd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_status   (status),
        .o_job_valid(job_valid),
        .i_job_ready(job_ready),
        .o_job      (job)
    );

    nmnd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_job_valid(job_valid),
        .o_job_ready(job_ready),
        .i_job      (job),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

endmodule

FILE: rtl/core/nmnd_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Properties on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module nmnd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input nmnd_pkg::t_out_word o_out_word
);
    import nmnd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_reset_no_accept: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input accepted during edge clear sweep");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    a_none_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.reachable |-> o_out_word.distance == DIST_NONE)
        else $error("unreachable result carries a distance");

    a_reach_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.reachable |-> o_out_word.distance != DIST_NONE)
        else $error("reachable result carries the no-path distance");

endmodule

bind nearest_marked_node_distance nmnd_checker u_nmnd_checker (.*);
